// ===== sv/rccc_pkg.sv =====
// Shared types, character codes and class tables for the bracket-expression compiler.
// No dependencies; used by rccc_step and regex_char_class_compiler_top.
`default_nettype none

package rccc_pkg;

	typedef enum logic [1:0] {
		ST_CONTINUE = 2'd0,
		ST_COMPLETE = 2'd1,
		ST_FAIL     = 2'd2
	} status_t;

	// Parser state carried from one character to the next
	typedef struct packed {
		logic [127:0] member_set;
		logic [6:0]   prev_char;
		logic         negating;
		logic         range_open;
		logic         escape_pending;
		logic         neg_member_seen;
		logic [1:0]   hex_phase;
		logic [3:0]   hex_high_nibble;
	} state_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LBRKT  = 8'h5B;
	localparam logic [7:0] CH_RBRKT  = 8'h5D;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_LC_D   = 8'h64;
	localparam logic [7:0] CH_LC_W   = 8'h77;
	localparam logic [7:0] CH_LC_S   = 8'h73;
	localparam logic [7:0] CH_UC_D   = 8'h44;
	localparam logic [7:0] CH_UC_W   = 8'h57;
	localparam logic [7:0] CH_UC_S   = 8'h53;

	localparam logic [1:0] HEX_IDLE = 2'd0;
	localparam logic [1:0] HEX_HIGH = 2'd1;
	localparam logic [1:0] HEX_LOW  = 2'd2;

	// Class sets, bit c for character c
	localparam logic [127:0] DIGIT_CLS = {64'h0000000000000000, 64'h03FF000000000000};
	localparam logic [127:0] WORD_CLS  = {64'h07FFFFFE87FFFFFE, 64'h03FF000000000000};
	localparam logic [127:0] SPACE_CLS = {64'h0000000000000000, 64'h0000000100002600};

	localparam state_t STATE_RESET = '{
		member_set:      '0,
		prev_char:       CH_LBRKT[6:0],
		negating:        1'b0,
		range_open:      1'b0,
		escape_pending:  1'b0,
		neg_member_seen: 1'b0,
		hex_phase:       HEX_IDLE,
		hex_high_nibble: 4'h0
	};

	// Bits lo..hi inclusive, one comparator pair per character
	function automatic logic [127:0] range_mask(input logic [6:0] lo, input logic [6:0] hi);
		logic [127:0] m;
		for (int i = 0; i < 128; i++) begin
			m[i] = (7'(i) >= lo) && (7'(i) <= hi);
		end
		return m;
	endfunction

	function automatic logic [127:0] char_bit(input logic [6:0] c);
		return 128'(1) << c;
	endfunction

	function automatic logic [127:0] apply_mask(input logic [127:0] s, input logic [127:0] m,
			input logic remove);
		return remove ? (s & ~m) : (s | m);
	endfunction

	// {valid, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else begin
			r = 5'h00;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/rccc_step.sv =====
// Next-state logic for one bracket-expression character: parser update and set edit.
// Depends on rccc_pkg.
`default_nettype none

module rccc_step (
	input  wire logic              start_class,
	input  wire logic [7:0]        current_char,
	input  wire logic [7:0]        lookahead_char,
	input  wire rccc_pkg::state_t  state_in,
	output rccc_pkg::state_t       state_out,
	output rccc_pkg::status_t      status
);

	rccc_pkg::state_t cur;
	logic [4:0]       hex_dec;
	logic [7:0]       hex_val;
	logic             hex_final;
	logic [6:0]       range_end;
	logic [127:0]     rng;
	logic             rng_inverted;

	assign cur       = start_class ? rccc_pkg::STATE_RESET : state_in;
	assign hex_dec   = rccc_pkg::hex_decode(current_char);
	assign hex_val   = {cur.hex_high_nibble, hex_dec[3:0]};
	assign hex_final = (cur.hex_phase != rccc_pkg::HEX_IDLE);
	// range end is the decoded hex value while an escape is being read
	assign range_end    = hex_final ? hex_val[6:0] : current_char[6:0];
	assign rng          = rccc_pkg::range_mask(cur.prev_char, range_end);
	assign rng_inverted = cur.prev_char > range_end;

	always_comb begin
		state_out = cur;
		status    = rccc_pkg::ST_CONTINUE;
		if (current_char[7]) begin
			status = rccc_pkg::ST_FAIL;
		end else begin
			unique case (current_char)
				rccc_pkg::CH_NUL, rccc_pkg::CH_LBRKT: begin
					status = rccc_pkg::ST_FAIL;
				end
				rccc_pkg::CH_RBRKT: begin
					if (cur.negating && !cur.neg_member_seen && !cur.range_open) begin
						status = rccc_pkg::ST_FAIL;
					end else begin
						if (cur.range_open) begin
							// dangling range: start char and dash are taken literally
							state_out.member_set = rccc_pkg::apply_mask(cur.member_set,
								rccc_pkg::char_bit(cur.prev_char) |
								rccc_pkg::char_bit(rccc_pkg::CH_DASH[6:0]), cur.negating);
							if (cur.negating) state_out.neg_member_seen = 1'b1;
						end
						status = rccc_pkg::ST_COMPLETE;
					end
				end
				rccc_pkg::CH_DASH: begin
					if (cur.escape_pending || cur.prev_char == rccc_pkg::CH_LBRKT[6:0]) begin
						state_out.member_set = cur.member_set |
							rccc_pkg::char_bit(rccc_pkg::CH_DASH[6:0]);
						state_out.escape_pending = 1'b0;
					end else if (cur.prev_char == rccc_pkg::CH_DASH[6:0] ||
							cur.prev_char == rccc_pkg::CH_CARET[6:0]) begin
						status = rccc_pkg::ST_FAIL;
					end else begin
						state_out.range_open = 1'b1;
					end
				end
				rccc_pkg::CH_CARET: begin
					if (cur.prev_char == rccc_pkg::CH_LBRKT[6:0] && !cur.negating &&
							!cur.escape_pending) begin
						state_out.negating   = 1'b1;
						state_out.member_set = ~cur.member_set;
					end else begin
						state_out.member_set = rccc_pkg::apply_mask(cur.member_set,
							rccc_pkg::char_bit(rccc_pkg::CH_CARET[6:0]), cur.negating);
						if (cur.negating) state_out.neg_member_seen = 1'b1;
						state_out.escape_pending = 1'b0;
					end
				end
				rccc_pkg::CH_BSLASH: begin
					if (cur.prev_char == rccc_pkg::CH_DASH[6:0] ||
							(cur.range_open && lookahead_char != rccc_pkg::CH_X)) begin
						status = rccc_pkg::ST_FAIL;
					end else begin
						state_out.escape_pending = 1'b1;
					end
				end
				default: begin
					if (hex_final) begin
						if (!hex_dec[4]) begin
							status = rccc_pkg::ST_FAIL;
						end else if (cur.hex_phase == rccc_pkg::HEX_HIGH) begin
							state_out.hex_high_nibble = hex_dec[3:0];
							state_out.hex_phase       = rccc_pkg::HEX_LOW;
						end else if (hex_val[7]) begin
							status = rccc_pkg::ST_FAIL;
						end else begin
							state_out.hex_phase = rccc_pkg::HEX_IDLE;
							if (cur.range_open) begin
								state_out.range_open = 1'b0;
								if (rng_inverted) begin
									status = rccc_pkg::ST_FAIL;
								end else begin
									state_out.member_set = rccc_pkg::apply_mask(
										cur.member_set, rng, cur.negating);
									if (cur.negating) state_out.neg_member_seen = 1'b1;
									state_out.prev_char = current_char[6:0];
								end
							end else if (lookahead_char == rccc_pkg::CH_DASH) begin
								// value becomes the start of a range
								state_out.prev_char = hex_val[6:0];
							end else begin
								state_out.member_set = rccc_pkg::apply_mask(cur.member_set,
									rccc_pkg::char_bit(hex_val[6:0]), cur.negating);
								if (cur.negating) state_out.neg_member_seen = 1'b1;
								state_out.prev_char = current_char[6:0];
							end
						end
					end else if (cur.escape_pending) begin
						state_out.escape_pending = 1'b0;
						unique case (current_char)
							rccc_pkg::CH_X:    state_out.hex_phase = rccc_pkg::HEX_HIGH;
							rccc_pkg::CH_LC_D: state_out.member_set =
								cur.member_set | rccc_pkg::DIGIT_CLS;
							rccc_pkg::CH_LC_W: state_out.member_set =
								cur.member_set | rccc_pkg::WORD_CLS;
							rccc_pkg::CH_LC_S: state_out.member_set =
								cur.member_set | rccc_pkg::SPACE_CLS;
							rccc_pkg::CH_UC_D: state_out.member_set =
								cur.member_set | ~rccc_pkg::DIGIT_CLS;
							rccc_pkg::CH_UC_W: state_out.member_set =
								cur.member_set | ~rccc_pkg::WORD_CLS;
							rccc_pkg::CH_UC_S: state_out.member_set =
								cur.member_set | ~rccc_pkg::SPACE_CLS;
							default:           status = rccc_pkg::ST_FAIL;
						endcase
					end else if (cur.prev_char == rccc_pkg::CH_LBRKT[6:0] &&
							current_char == rccc_pkg::CH_DOT) begin
						state_out.member_set = ~cur.member_set;
						state_out.prev_char  = current_char[6:0];
					end else if (cur.range_open) begin
						state_out.range_open = 1'b0;
						if (rng_inverted) begin
							status = rccc_pkg::ST_FAIL;
						end else begin
							state_out.member_set = rccc_pkg::apply_mask(cur.member_set, rng,
								cur.negating);
							if (cur.negating) state_out.neg_member_seen = 1'b1;
							state_out.prev_char = current_char[6:0];
						end
					end else begin
						if (lookahead_char != rccc_pkg::CH_DASH) begin
							state_out.member_set = rccc_pkg::apply_mask(cur.member_set,
								rccc_pkg::char_bit(current_char[6:0]), cur.negating);
							if (cur.negating) state_out.neg_member_seen = 1'b1;
						end
						state_out.prev_char = current_char[6:0];
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/regex_char_class_compiler_top.sv =====
// Top level of the bracket-expression compiler: stream ports, input and result registers.
// Depends on rccc_pkg and rccc_step.
//
//   channel  | dir | tdata (low bit up)                           | tuser
//   s_axis   | in  | current_char[7:0], lookahead_char[15:8]      | start_class
//   m_axis   | out | set_low_half[63:0], set_high_half[127:64]    | status[1:0]
//
// One character per clock sustained while m_axis takes every result; a character passes
// through the input register and then the result register, which drives m_axis.
// The parser state updates as the character leaves the input register, so each character
// sees the state left by the one before it without any bubble.
// arst_n clears the parser state to empty set, previous char '[' and all flags low.
// A stalled m_axis holds the result; one more character can wait in the input register.
`default_nettype none

module regex_char_class_compiler_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [15:0]  s_axis_tdata,   // current_char[7:0], lookahead_char[15:8]
	input  wire logic         s_axis_tuser,   // start_class
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [127:0]      m_axis_tdata,   // set_low_half[63:0], set_high_half[127:64]
	output logic [1:0]        m_axis_tuser    // status[1:0]
);

	// input register
	logic       valid_s1;
	logic       start_s1;
	logic [7:0] cur_s1;
	logic [7:0] look_s1;

	rccc_pkg::state_t  state_q;
	rccc_pkg::state_t  state_next;
	rccc_pkg::status_t status_next;

	logic         out_valid_q;
	logic [127:0] out_set_q;
	logic [1:0]   out_status_q;

	logic advance;

	// stage 1 moves on whenever the result register is free or being drained
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			start_s1 <= s_axis_tuser;
			cur_s1   <= s_axis_tdata[7:0];
			look_s1  <= s_axis_tdata[15:8];
		end
	end

	rccc_step u_step (
		.start_class    (start_s1),
		.current_char   (cur_s1),
		.lookahead_char (look_s1),
		.state_in       (state_q),
		.state_out      (state_next),
		.status         (status_next)
	);

	// parser state is control state: reset and committed once per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rccc_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_set_q    <= state_next.member_set;
			out_status_q <= status_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_set_q;
	assign m_axis_tuser  = out_status_q;

endmodule

`default_nettype wire

// ===== dv/class_set_checker.sv =====
// Checker for the bracket-expression compiler: predicts the status and membership set per character.
// Depends on rccc_pkg for status codes and character codes; watches both stream channels.
// Hands its mismatch count, outstanding count and tallies to the testbench top.

module class_set_checker
	import rccc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [15:0]  s_axis_tdata,   // current_char[7:0], lookahead_char[15:8]
	input  logic         s_axis_tuser,   // start_class
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [127:0] m_axis_tdata,   // set_low_half[63:0], set_high_half[127:64]
	input  logic [1:0]   m_axis_tuser,   // status[1:0]
	output int           mismatches,
	output int           pending,
	output int           compared,
	output int           completes,
	output int           fails
);

	localparam logic [7:0] ASCII_MAX  = 8'h7F;
	localparam logic [7:0] DIGIT_ZERO = "0";
	localparam logic [7:0] DIGIT_NINE = "9";
	localparam logic [7:0] LC_A       = "a";
	localparam logic [7:0] LC_F       = "f";
	localparam logic [7:0] UC_A       = "A";
	localparam logic [7:0] UC_F       = "F";
	localparam int         MAX_PRINTED = 40;

	// bit c stands for character c
	localparam logic [127:0] DIGIT_BITS = {64'h0, 64'h03FF000000000000};
	localparam logic [127:0] WORD_BITS  = {64'h07FFFFFE87FFFFFE, 64'h03FF000000000000};
	localparam logic [127:0] SPACE_BITS = {64'h0, 64'h0000000100002600};

	typedef struct {
		status_t      status;
		logic [127:0] members;
	} class_result_t;

	class_result_t expected_results[$];

	// parser copy
	logic [127:0] set_bits     = '0;
	logic [7:0]   last_char    = CH_LBRKT;
	logic         negated      = 1'b0;
	logic         in_range     = 1'b0;
	logic         escaped      = 1'b0;
	logic         removal_seen = 1'b0;
	logic [1:0]   hex_step     = HEX_IDLE;
	logic [3:0]   hex_hi       = 4'h0;

	function automatic void clear_parser();
		set_bits     = '0;
		last_char    = CH_LBRKT;
		negated      = 1'b0;
		in_range     = 1'b0;
		escaped      = 1'b0;
		removal_seen = 1'b0;
		hex_step     = HEX_IDLE;
		hex_hi       = 4'h0;
	endfunction

	function automatic logic [127:0] char_span(int lo, int hi);
		logic [127:0] m;
		for (int i = 0; i < 128; i++) begin
			m[i] = (i >= lo) && (i <= hi);
		end
		return m;
	endfunction

	// adds lo..hi, or removes it under negation; an upside-down span is refused
	function automatic bit mark_span(int lo, int hi);
		if (lo > hi) return 1'b0;
		if (negated) begin
			set_bits     = set_bits & ~char_span(lo, hi);
			removal_seen = 1'b1;
		end else begin
			set_bits = set_bits | char_span(lo, hi);
		end
		return 1'b1;
	endfunction

	function automatic int hex_nibble(logic [7:0] c);
		if (c >= DIGIT_ZERO && c <= DIGIT_NINE) return int'(c - DIGIT_ZERO);
		if (c >= LC_A && c <= LC_F) return int'(c - LC_A) + 10;
		if (c >= UC_A && c <= UC_F) return int'(c - UC_A) + 10;
		return -1;
	endfunction

	function automatic status_t parse_char(logic [7:0] c, logic [7:0] la);
		int         nib;
		logic [7:0] val;
		if (c > ASCII_MAX) return ST_FAIL;
		case (c)
			CH_NUL, CH_LBRKT: return ST_FAIL;
			CH_RBRKT: begin
				if (negated && !removal_seen && !in_range) return ST_FAIL;
				// dangling range: its start and the dash itself are added, or removed under negation
				if (in_range) begin
					void'(mark_span(last_char, last_char));
					void'(mark_span(CH_DASH, CH_DASH));
				end
				return ST_COMPLETE;
			end
			CH_DASH: begin
				if (escaped || last_char == CH_LBRKT) begin
					set_bits[CH_DASH] = 1'b1;
					escaped = 1'b0;
				end else if (last_char == CH_DASH || last_char == CH_CARET) begin
					return ST_FAIL;
				end else begin
					in_range = 1'b1;
				end
				return ST_CONTINUE;
			end
			CH_CARET: begin
				if (last_char == CH_LBRKT && !negated && !escaped) begin
					negated  = 1'b1;
					set_bits = ~set_bits;
				end else begin
					void'(mark_span(CH_CARET, CH_CARET));
					escaped = 1'b0;
				end
				return ST_CONTINUE;
			end
			CH_BSLASH: begin
				if (last_char == CH_DASH || (in_range && la != CH_X)) return ST_FAIL;
				escaped = 1'b1;
				return ST_CONTINUE;
			end
			default: ;
		endcase

		if (hex_step != HEX_IDLE) begin
			nib = hex_nibble(c);
			if (nib < 0) return ST_FAIL;
			if (hex_step == HEX_HIGH) begin
				hex_hi   = nib[3:0];
				hex_step = HEX_LOW;
				return ST_CONTINUE;
			end
			val = {hex_hi, nib[3:0]};
			if (val > ASCII_MAX) return ST_FAIL;
			hex_step = HEX_IDLE;
			if (in_range) begin
				in_range = 1'b0;
				if (!mark_span(last_char, val)) return ST_FAIL;
			end else begin
				last_char = val;
				if (la == CH_DASH) return ST_CONTINUE;
				void'(mark_span(val, val));
			end
		end else if (escaped) begin
			escaped = 1'b0;
			case (c)
				CH_X: begin
					hex_step = HEX_HIGH;
					return ST_CONTINUE;
				end
				CH_LC_D: set_bits = set_bits | DIGIT_BITS;
				CH_LC_W: set_bits = set_bits | WORD_BITS;
				CH_LC_S: set_bits = set_bits | SPACE_BITS;
				CH_UC_D: set_bits = set_bits | ~DIGIT_BITS;
				CH_UC_W: set_bits = set_bits | ~WORD_BITS;
				CH_UC_S: set_bits = set_bits | ~SPACE_BITS;
				default: return ST_FAIL;
			endcase
			return ST_CONTINUE;
		end else if (last_char == CH_LBRKT && c == CH_DOT) begin
			set_bits = ~set_bits;
		end else if (in_range) begin
			in_range = 1'b0;
			if (!mark_span(last_char, c)) return ST_FAIL;
		end else if (la != CH_DASH) begin
			void'(mark_span(c, c));
		end
		last_char = c;
		return ST_CONTINUE;
	endfunction

	task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
		if (mismatches < MAX_PRINTED)
			$display("MISMATCH result %0d %s: got %h, predicted %h", compared, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		class_result_t prediction;
		if (!arst_n) begin
			clear_parser();
			expected_results.delete();
			pending    = 0;
			mismatches = 0;
			compared   = 0;
			completes  = 0;
			fails      = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected transfer", m_axis_tdata, '0);
				end else begin
					prediction = expected_results.pop_front();
					compared++;
					if (m_axis_tuser !== prediction.status)
						report_mismatch("status", m_axis_tuser, prediction.status);
					if (m_axis_tdata[63:0] !== prediction.members[63:0])
						report_mismatch("set_low_half", m_axis_tdata[63:0],
							prediction.members[63:0]);
					if (m_axis_tdata[127:64] !== prediction.members[127:64])
						report_mismatch("set_high_half", m_axis_tdata[127:64],
							prediction.members[127:64]);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser) clear_parser();
				prediction.status  = parse_char(s_axis_tdata[7:0], s_axis_tdata[15:8]);
				prediction.members = set_bits;
				if (prediction.status == ST_COMPLETE) completes++;
				if (prediction.status == ST_FAIL) fails++;
				expected_results.push_back(prediction);
			end
			pending = expected_results.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
// Top of the bracket-expression compiler testbench: clock, reset, stimulus, result sink, verdict.
// Depends on rccc_pkg, regex_char_class_compiler_top and class_set_checker.

module testbench;
	import rccc_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int ITEM_TARGET   = 1000;
	localparam int LONG_HOLD_AT  = 300;   // result count at which the sink holds off
	localparam int LONG_HOLD     = 300;   // cycles of that hold-off
	localparam int DRAIN_AT      = 500;   // character count at which the source drains

	localparam logic [7:0] DIGIT_ZERO = "0";
	localparam logic [7:0] LC_A       = "a";
	localparam logic [7:0] UC_A       = "A";
	localparam logic [7:0] NOT_HEX    = "g";
	localparam logic [7:0] ASCII_MAX  = 8'h7F;
	localparam logic [7:0] CLASS_LETTERS [6] = '{CH_LC_D, CH_LC_W, CH_LC_S,
		CH_UC_D, CH_UC_W, CH_UC_S};

	// building blocks of a random bracket expression
	typedef enum int {
		P_LITERAL, P_RANGE, P_CLASS, P_HEX, P_HEX_RANGE,
		P_ESC_CARET, P_ESC_DASH, P_BAD_ESC, P_STRAY
	} piece_kind_t;

	logic         clk            = 1'b0;
	logic         arst_n         = 1'b0;
	logic         s_axis_tvalid  = 1'b0;
	logic         s_axis_tready;
	logic [15:0]  s_axis_tdata   = '0;   // current_char[7:0], lookahead_char[15:8]
	logic         s_axis_tuser   = 1'b0; // start_class
	logic         m_axis_tvalid;
	logic         m_axis_tready  = 1'b0;
	logic [127:0] m_axis_tdata;          // set_low_half[63:0], set_high_half[127:64]
	logic [1:0]   m_axis_tuser;          // status[1:0]

	int mismatches, pending, compared, completes, fails;
	int items_sent   = 0;
	int classes_sent = 0;
	int cycles       = 0;
	bit quick_send   = 1'b0;

	// characters of the expression being sent
	logic [7:0] expr[$];

	regex_char_class_compiler_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	class_set_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.pending       (pending),
		.compared      (compared),
		.completes     (completes),
		.fails         (fails)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// single reset at the start, released on a falling edge
	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
			$display("Some tests failed");
			$finish;
		end
	end

	// One transfer on s_axis. Entered and left on a falling edge; with no gap the valid simply
	// stays high and only the payload changes, so valid never gets two updates in one step.
	task automatic send_item(bit start, logic [7:0] c, logic [7:0] la);
		int gap;
		gap = quick_send ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {la, c};
		s_axis_tuser  <= start;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		items_sent++;
	endtask

	// Sends expr; lookahead is the next character, random after the last one and now and
	// then random anywhere to break the usual pairing.
	task automatic send_expr(bit start);
		logic [7:0] la;
		for (int i = 0; i < expr.size(); i++) begin
			if (i + 1 < expr.size() && $urandom_range(0, 32) != 0) la = expr[i + 1];
			else la = 8'($urandom_range(0, 255));
			send_item(start && i == 0, expr[i], la);
		end
		classes_sent++;
	endtask

	task automatic send_text(string text);
		expr.delete();
		for (int i = 0; i < text.len(); i++) expr.push_back(text[i]);
		send_expr(1'b1);
	endtask

	// printable or control character that carries no meaning in a class
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do begin
			if ($urandom_range(0, 7) == 0) c = 8'($urandom_range(1, 127));
			else c = 8'($urandom_range(32, 126));
		end while (c == CH_RBRKT || c == CH_DASH || c == CH_CARET || c == CH_BSLASH ||
			c == CH_LBRKT);
		return c;
	endfunction

	function automatic logic [7:0] hex_digit(logic [3:0] n);
		if (n < 10) return DIGIT_ZERO + 8'(n);
		return ($urandom_range(0, 1) ? LC_A : UC_A) + 8'(n) - 8'd10;
	endfunction

	// \x and two digits; the odd one is out of range or carries a non-hex digit
	task automatic push_hex(logic [7:0] v);
		expr.push_back(CH_BSLASH);
		expr.push_back(CH_X);
		expr.push_back(($urandom_range(0, 15) == 0) ? NOT_HEX : hex_digit(v[7:4]));
		expr.push_back(($urandom_range(0, 15) == 0) ? NOT_HEX : hex_digit(v[3:0]));
	endtask

	function automatic piece_kind_t pick_piece();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return P_LITERAL;
		if (r < 45) return P_RANGE;
		if (r < 60) return P_CLASS;
		if (r < 70) return P_HEX;
		if (r < 80) return P_HEX_RANGE;
		if (r < 85) return P_ESC_CARET;
		if (r < 90) return P_ESC_DASH;
		if (r < 95) return P_BAD_ESC;
		return P_STRAY;
	endfunction

	task automatic add_piece(piece_kind_t kind);
		logic [7:0] lo, hi;
		case (kind)
			P_LITERAL: expr.push_back(plain_char());
			P_RANGE: begin
				lo = plain_char();
				hi = plain_char();
				// mostly the right way round; the rest are upside-down ranges
				if (lo > hi && $urandom_range(0, 4) != 0) begin
					lo = hi ^ lo;
					hi = hi ^ lo;
					lo = hi ^ lo;
				end
				expr.push_back(lo);
				expr.push_back(CH_DASH);
				expr.push_back(hi);
			end
			P_CLASS: begin
				expr.push_back(CH_BSLASH);
				expr.push_back(CLASS_LETTERS[$urandom_range(0, 5)]);
			end
			P_HEX: begin
				if ($urandom_range(0, 9) == 0) push_hex(8'($urandom_range(128, 255)));
				else push_hex(8'($urandom_range(0, 127)));
			end
			P_HEX_RANGE: begin
				lo = plain_char();
				expr.push_back(lo);
				expr.push_back(CH_DASH);
				if ($urandom_range(0, 4) == 0) push_hex(8'($urandom_range(0, 127)));
				else push_hex(8'($urandom_range(lo, ASCII_MAX)));
			end
			P_ESC_CARET: begin
				expr.push_back(CH_BSLASH);
				expr.push_back(CH_CARET);
			end
			P_ESC_DASH: begin
				expr.push_back(CH_BSLASH);
				expr.push_back(CH_DASH);
			end
			P_BAD_ESC: begin
				expr.push_back(CH_BSLASH);
				expr.push_back(plain_char());
			end
			default: expr.push_back(8'($urandom_range(0, 255)));
		endcase
	endtask

	// Mostly well-formed expressions with random content; a tenth are pure noise bytes.
	task automatic build_expression();
		int r;
		expr.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8)) expr.push_back(8'($urandom_range(0, 255)));
			return;
		end
		r = $urandom_range(0, 99);
		if (r < 25) expr.push_back(CH_CARET);
		else if (r < 35) expr.push_back(CH_DOT);
		else if (r < 43) expr.push_back(CH_DASH);
		repeat ($urandom_range(0, 6)) add_piece(pick_piece());
		if ($urandom_range(0, 9) != 0) expr.push_back(CH_RBRKT);
		// carry on past the closing bracket without a restart now and then
		if ($urandom_range(0, 9) == 0) begin
			add_piece(P_LITERAL);
			expr.push_back(CH_RBRKT);
		end
	endtask

	// stimulus and verdict
	initial begin
		bit drained;
		drained = 1'b0;
		wait (arst_n);
		@(negedge clk);

		// directed: NUL, non-ASCII and open bracket fail; negated range with a negated
		// escape; leading dot; hex range end; upside-down range; negation with nothing removed
		send_item(1'b1, CH_NUL, 8'h00);
		send_item(1'b0, 8'hFF, 8'hFF);
		send_item(1'b0, CH_LBRKT, CH_RBRKT);
		send_text("^a-z\\D]");
		send_text(".]");
		send_text("\\x41-\\x5a]");
		send_text("z-a");
		send_text("^]");

		// random part; a fifth of the expressions go back to back with no gaps
		while (items_sent < ITEM_TARGET) begin
			quick_send = ($urandom_range(0, 4) == 0);
			build_expression();
			send_expr($urandom_range(0, 9) != 0);
			// once, let every outstanding result come back before going on
			if (!drained && items_sent >= DRAIN_AT) begin
				drained = 1'b1;
				s_axis_tvalid <= 1'b0;
				wait (pending == 0);
				@(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (8) @(posedge clk);
		$display("Sent %0d expressions, %0d characters, with gaps, stalls and a long sink hold-off.",
			classes_sent, items_sent);
		$display("Compared %0d results: %0d completed classes, %0d failing characters.",
			compared, completes, fails);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Result sink: random stalls per transfer, quiet stretches with no stalls, and once a long
	// hold-off so the block backs up and drops s_axis_tready.
	initial begin : result_sink
		int hold;
		int taken;
		bit quick;
		taken = 0;
		quick = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (taken == LONG_HOLD_AT) hold = LONG_HOLD;
			else hold = quick ? 0 : $urandom_range(0, 19);
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
			taken++;
			if (taken % 40 == 0) quick = ($urandom_range(0, 2) == 0);
		end
	end

endmodule
